FILE: rtl/core/dpp_pkg.sv
// Shared types and constants for the deadband proportional pointing block.
`default_nettype none

package dpp_pkg;

  // Field widths
  localparam int SX_W       = 17;
  localparam int CONF_W     = 16;
  localparam int SIZE_W     = 12;
  localparam int DEAD_W     = 15;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int ANG_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Datapath widths
  localparam int ABS_D_W     = SX_W;        // |p - 8*S| fits in 17 bits
  localparam int ERR_W       = 18;          // Q3.15 error, saturates at 4.0
  localparam int ERR_SHIFT   = 12;          // 1/16 pixel over half size -> Q3.15
  localparam int Q15_FRAC    = 15;
  localparam int M_W         = 30;          // rescaled error, clamped at 2^29
  localparam int GAIN_SHIFT  = 14;
  localparam int PROD_W      = GAIN_W + M_W;
  localparam int DIV_NUM_W   = 34;
  localparam int DIV_DEN_W   = 16;
  localparam int DIV_BITS    = 2;           // quotient bits per cycle
  localparam int DIV_STEPS   = DIV_NUM_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [ERR_W-1:0]     ERR_SAT = ERR_W'(131072);
  localparam logic [M_W-1:0]       M_SAT   = M_W'(1) << (M_W - 1);
  localparam logic [DIV_DEN_W-1:0] Q15_ONE = DIV_DEN_W'(32768);

  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [STATUS_W-1:0] {
    GATE_TRACK    = 2'd0,
    GATE_LOW_CONF = 2'd1,
    GATE_BAD_SIZE = 2'd2
  } gate_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_CONF   = 4'd0,
    CFG_WIDTH      = 4'd1,
    CFG_HEIGHT     = 4'd2,
    CFG_DEAD_ZONE  = 4'd3,
    CFG_PAN_GAIN   = 4'd4,
    CFG_TILT_GAIN  = 4'd5,
    CFG_PAN_LIMIT  = 4'd6,
    CFG_TILT_LIMIT = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [ABS_D_W-1:0] abs_d;
    logic               neg;
  } axis_in_t;

  typedef struct packed {
    gate_t    status;
    axis_in_t pan;
    axis_in_t tilt;
  } job_t;

  typedef struct packed {
    logic        [SIZE_W-1:0] size;
    logic signed [GAIN_W-1:0] gain;
    logic        [LIM_W-1:0]  limit;
    logic        [DEAD_W-1:0] dead;
  } axis_cfg_t;

  typedef struct packed {
    logic start;
    logic ack;
  } axis_ctl_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] angle;
  } axis_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/dpp_intf.sv
// Channel interfaces: input beats, result beats and register writes.
`default_nettype none

interface dpp_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [dpp_pkg::SX_W-1:0]  sun_x;
  logic signed [dpp_pkg::SX_W-1:0]  sun_y;
  logic        [dpp_pkg::CONF_W-1:0] confidence;

  modport source (output valid, sun_x, sun_y, confidence, input ready);
  modport sink   (input valid, sun_x, sun_y, confidence, output ready);
endinterface

interface dpp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dpp_pkg::ANG_W-1:0]    pan_angle;
  logic signed [dpp_pkg::ANG_W-1:0]    tilt_angle;
  logic        [dpp_pkg::STATUS_W-1:0] gate_status;

  modport source (output valid, pan_angle, tilt_angle, gate_status, input ready);
  modport sink   (input valid, pan_angle, tilt_angle, gate_status, output ready);
endinterface

interface dpp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [dpp_pkg::CFG_IDX_W-1:0]      index;
  logic [dpp_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dpp_front.sv
// Front end: gates an input beat and forms per-axis offset magnitude and sign.
`default_nettype none

module dpp_front (
  input  logic signed [dpp_pkg::SX_W-1:0]   sun_x,
  input  logic signed [dpp_pkg::SX_W-1:0]   sun_y,
  input  logic        [dpp_pkg::CONF_W-1:0] confidence,
  input  logic        [dpp_pkg::CONF_W-1:0] min_conf,
  input  logic        [dpp_pkg::SIZE_W-1:0] image_width,
  input  logic        [dpp_pkg::SIZE_W-1:0] image_height,
  output dpp_pkg::job_t                     job
);

  localparam int D_W = dpp_pkg::SX_W + 1;

  // d = p - 8*S, then magnitude and sign
  function automatic dpp_pkg::axis_in_t offset(
    input logic signed [dpp_pkg::SX_W-1:0]   p,
    input logic        [dpp_pkg::SIZE_W-1:0] s
  );
    logic signed [D_W-1:0] d;
    logic signed [D_W-1:0] centre;
    dpp_pkg::axis_in_t     r;
    centre  = $signed({{(D_W - dpp_pkg::SIZE_W - 3){1'b0}}, s, 3'b000});
    d       = $signed({p[dpp_pkg::SX_W-1], p}) - centre;
    r.neg   = d[D_W-1];
    r.abs_d = d[D_W-1] ? dpp_pkg::ABS_D_W'(-d) : dpp_pkg::ABS_D_W'(d);
    return r;
  endfunction

  always_comb begin
    job.pan  = offset(sun_x, image_width);
    job.tilt = offset(sun_y, image_height);
    if (confidence < min_conf) begin
      job.status = dpp_pkg::GATE_LOW_CONF;
    end else if (image_width == '0 || image_height == '0) begin
      job.status = dpp_pkg::GATE_BAD_SIZE;
    end else begin
      job.status = dpp_pkg::GATE_TRACK;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dpp_queue.sv
// Short register queue between front end and back end.
`default_nettype none

module dpp_queue #(
  parameter int DEPTH = dpp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dpp_pkg::job_t push_data,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output dpp_pkg::job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dpp_pkg::job_t     entries_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dpp_axis.sv
// One axis: normalize, deadband rescale, gain and clamp on one radix-4 divider used for both divisions.
`default_nettype none

module dpp_axis (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dpp_pkg::axis_ctl_t    ctl,
  input  dpp_pkg::axis_in_t     job_ax,
  input  dpp_pkg::axis_cfg_t    cfg,
  output dpp_pkg::axis_sts_t    sts
);

  localparam int NUM_W  = dpp_pkg::DIV_NUM_W;
  localparam int DEN_W  = dpp_pkg::DIV_DEN_W;
  localparam int MAG_W  = dpp_pkg::PROD_W - dpp_pkg::GAIN_SHIFT;

  typedef enum logic [6:0] {
    AX_IDLE  = 7'b0000001,
    AX_DIV1  = 7'b0000010,
    AX_CHK   = 7'b0000100,
    AX_DIV2  = 7'b0001000,
    AX_MUL   = 7'b0010000,
    AX_CLAMP = 7'b0100000,
    AX_DONE  = 7'b1000000
  } ax_state_t;

  ax_state_t                            state_r, state_nxt;
  logic [dpp_pkg::DIV_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [DEN_W-1:0]                     rem_r, rem_nxt;
  logic [NUM_W-1:0]                     num_r, num_nxt;
  logic [DEN_W-1:0]                     dv_r, dv_nxt;
  logic                                 neg_r, neg_nxt;
  logic [dpp_pkg::PROD_W-1:0]           prod_r, prod_nxt;
  logic signed [dpp_pkg::ANG_W-1:0]     angle_r, angle_nxt;

  logic [DEN_W-1:0]                     rem_a;
  logic [NUM_W-1:0]                     num_a;
  logic [DEN_W:0]                       trial;
  logic [dpp_pkg::ERR_W-1:0]            ae;
  logic [dpp_pkg::ERR_W-1:0]            err_excess;
  logic [dpp_pkg::M_W-1:0]              m_sat;
  logic [dpp_pkg::GAIN_W-1:0]           gain_mag;
  logic [MAG_W-1:0]                     mag_full;
  logic [dpp_pkg::LIM_W-1:0]            mag_clamped;
  logic [dpp_pkg::ANG_W-1:0]            mag_ext;
  logic                                 flip;

  // Two restoring-division steps per cycle; quotient bits shift into num
  always_comb begin
    rem_a = rem_r;
    num_a = num_r;
    trial = '0;
    for (int k = 0; k < dpp_pkg::DIV_BITS; k++) begin
      trial = {rem_a, num_a[NUM_W-1]};
      num_a = {num_a[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dv_r}) begin
        rem_a    = DEN_W'(trial - {1'b0, dv_r});
        num_a[0] = 1'b1;
      end else begin
        rem_a = trial[DEN_W-1:0];
      end
    end
  end

  assign ae = (num_r > NUM_W'(dpp_pkg::ERR_SAT)) ? dpp_pkg::ERR_SAT
                                                  : num_r[dpp_pkg::ERR_W-1:0];
  assign err_excess = ae - dpp_pkg::ERR_W'(cfg.dead);
  // Past 2^29 the product for any nonzero gain already exceeds any limit
  assign m_sat = (num_r >= NUM_W'(dpp_pkg::M_SAT)) ? dpp_pkg::M_SAT
                                                   : num_r[dpp_pkg::M_W-1:0];
  assign gain_mag = cfg.gain[dpp_pkg::GAIN_W-1] ? dpp_pkg::GAIN_W'(-cfg.gain)
                                                : dpp_pkg::GAIN_W'(cfg.gain);
  assign mag_full = prod_r[dpp_pkg::PROD_W-1:dpp_pkg::GAIN_SHIFT];
  assign mag_clamped = (mag_full > MAG_W'(cfg.limit)) ? cfg.limit
                                                      : mag_full[dpp_pkg::LIM_W-1:0];
  assign mag_ext = {1'b0, mag_clamped};
  assign flip    = neg_r ^ cfg.gain[dpp_pkg::GAIN_W-1];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    dv_nxt    = dv_r;
    neg_nxt   = neg_r;
    prod_nxt  = prod_r;
    angle_nxt = angle_r;
    unique case (state_r)
      AX_IDLE: begin
        if (ctl.start) begin
          neg_nxt   = job_ax.neg;
          num_nxt   = {{(NUM_W - dpp_pkg::ABS_D_W - dpp_pkg::ERR_SHIFT){1'b0}},
                       job_ax.abs_d, {dpp_pkg::ERR_SHIFT{1'b0}}};
          rem_nxt   = '0;
          dv_nxt    = DEN_W'(cfg.size);
          cnt_nxt   = '0;
          state_nxt = AX_DIV1;
        end
      end
      AX_DIV1: begin
        rem_nxt = rem_a;
        num_nxt = num_a;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == dpp_pkg::DIV_CNT_W'(dpp_pkg::DIV_STEPS - 1)) begin
          state_nxt = AX_CHK;
        end
      end
      AX_CHK: begin
        if (ae <= dpp_pkg::ERR_W'(cfg.dead)) begin
          angle_nxt = '0;
          state_nxt = AX_DONE;
        end else begin
          num_nxt   = {{(NUM_W - dpp_pkg::ERR_W - dpp_pkg::Q15_FRAC){1'b0}},
                       err_excess, {dpp_pkg::Q15_FRAC{1'b0}}};
          rem_nxt   = '0;
          dv_nxt    = dpp_pkg::Q15_ONE - DEN_W'(cfg.dead);
          cnt_nxt   = '0;
          state_nxt = AX_DIV2;
        end
      end
      AX_DIV2: begin
        rem_nxt = rem_a;
        num_nxt = num_a;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == dpp_pkg::DIV_CNT_W'(dpp_pkg::DIV_STEPS - 1)) begin
          state_nxt = AX_MUL;
        end
      end
      AX_MUL: begin
        prod_nxt  = dpp_pkg::PROD_W'(gain_mag * m_sat);
        state_nxt = AX_CLAMP;
      end
      AX_CLAMP: begin
        angle_nxt = flip ? $signed(~mag_ext + 1'b1) : $signed(mag_ext);
        state_nxt = AX_DONE;
      end
      AX_DONE: begin
        if (ctl.ack) begin
          state_nxt = AX_IDLE;
        end
      end
      default: state_nxt = AX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AX_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    num_r   <= num_nxt;
    dv_r    <= dv_nxt;
    neg_r   <= neg_nxt;
    prod_r  <= prod_nxt;
    angle_r <= angle_nxt;
  end

  assign sts.done  = (state_r == AX_DONE);
  assign sts.angle = angle_r;

endmodule

`default_nettype wire

FILE: rtl/core/dpp_back.sv
// Back end: pops jobs, runs both axis units and holds the result register.
`default_nettype none

module dpp_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  dpp_pkg::job_t                    job,
  output logic                             q_pop,
  input  dpp_pkg::axis_cfg_t               pan_cfg,
  input  dpp_pkg::axis_cfg_t               tilt_cfg,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dpp_pkg::ANG_W-1:0] pan_angle,
  output logic signed [dpp_pkg::ANG_W-1:0] tilt_angle,
  output dpp_pkg::gate_t                   gate_status
);

  logic                             busy_r, busy_nxt;
  dpp_pkg::gate_t                   status_r;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [dpp_pkg::ANG_W-1:0] pan_r, tilt_r;
  dpp_pkg::gate_t                   gate_r;

  dpp_pkg::axis_ctl_t               ax_ctl;
  dpp_pkg::axis_sts_t               pan_sts, tilt_sts;
  logic                             do_pop, tracking, result_ready, out_load;

  assign q_pop        = !busy_r;
  assign do_pop       = q_valid && !busy_r;
  assign tracking     = (status_r == dpp_pkg::GATE_TRACK);
  assign result_ready = busy_r && (!tracking || (pan_sts.done && tilt_sts.done));
  // result register frees up in the same cycle it is drained
  assign out_load     = result_ready && (!out_valid_r || out_ready);

  assign ax_ctl.start = do_pop && (job.status == dpp_pkg::GATE_TRACK);
  assign ax_ctl.ack   = out_load;

  dpp_axis u_pan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ax_ctl),
    .job_ax (job.pan),
    .cfg    (pan_cfg),
    .sts    (pan_sts)
  );

  dpp_axis u_tilt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ax_ctl),
    .job_ax (job.tilt),
    .cfg    (tilt_cfg),
    .sts    (tilt_sts)
  );

  always_comb begin
    busy_nxt = busy_r;
    if (do_pop) begin
      busy_nxt = 1'b1;
    end else if (out_load) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      status_r <= job.status;
    end
    if (out_load) begin
      pan_r  <= tracking ? pan_sts.angle  : '0;
      tilt_r <= tracking ? tilt_sts.angle : '0;
      gate_r <= status_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign pan_angle   = pan_r;
  assign tilt_angle  = tilt_r;
  assign gate_status = gate_r;

endmodule

`default_nettype wire

FILE: rtl/core/deadband_proportional_pointing_core.sv
// Top level: register file, front end, job queue, back end.
//
//   channel  dir  port     payload
//   ------------------------------------------------------------
//   input    in   in_if    sun_x, sun_y, confidence
//   result   out  out_if   pan_angle, tilt_angle, gate_status
//   config   in   cfg_if   index, data (always ready)
//
// A tracked beat's time in the back end is set by the radix-4 divisions on each
// axis (normalize, then deadband rescale, skipped inside the deadband); both axes
// run side by side. Gated beats (low confidence, zero size) skip the axis units.
// The front end accepts a beat every cycle while the queue has room.
// Reset is synchronous, active low; control and config registers return to their reset values.
`default_nettype none

module deadband_proportional_pointing_core #(
  parameter int Q_DEPTH = dpp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  dpp_in_if.sink      in_if,
  dpp_out_if.source   out_if,
  dpp_cfg_if.sink     cfg_if
);

  logic        [dpp_pkg::CONF_W-1:0] min_conf_r;
  logic        [dpp_pkg::SIZE_W-1:0] width_r;
  logic        [dpp_pkg::SIZE_W-1:0] height_r;
  logic        [dpp_pkg::DEAD_W-1:0] dead_r;
  logic signed [dpp_pkg::GAIN_W-1:0] pan_gain_r;
  logic signed [dpp_pkg::GAIN_W-1:0] tilt_gain_r;
  logic        [dpp_pkg::LIM_W-1:0]  pan_limit_r;
  logic        [dpp_pkg::LIM_W-1:0]  tilt_limit_r;

  dpp_pkg::job_t      front_job, q_job;
  logic               q_ready, q_valid, q_pop;
  dpp_pkg::axis_cfg_t pan_cfg, tilt_cfg;
  dpp_pkg::gate_t     gate_out;
  logic               cfg_we;

  assign cfg_if.ready = 1'b1;
  assign cfg_we       = cfg_if.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_conf_r   <= '0;
      width_r      <= dpp_pkg::WIDTH_RST;
      height_r     <= dpp_pkg::HEIGHT_RST;
      dead_r       <= '0;
      pan_gain_r   <= '0;
      tilt_gain_r  <= '0;
      pan_limit_r  <= '0;
      tilt_limit_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_if.index)
        dpp_pkg::CFG_MIN_CONF:   min_conf_r   <= cfg_if.data;
        dpp_pkg::CFG_WIDTH:      width_r      <= cfg_if.data[dpp_pkg::SIZE_W-1:0];
        dpp_pkg::CFG_HEIGHT:     height_r     <= cfg_if.data[dpp_pkg::SIZE_W-1:0];
        dpp_pkg::CFG_DEAD_ZONE:  dead_r       <= cfg_if.data[dpp_pkg::DEAD_W-1:0];
        dpp_pkg::CFG_PAN_GAIN:   pan_gain_r   <= $signed(cfg_if.data);
        dpp_pkg::CFG_TILT_GAIN:  tilt_gain_r  <= $signed(cfg_if.data);
        dpp_pkg::CFG_PAN_LIMIT:  pan_limit_r  <= cfg_if.data[dpp_pkg::LIM_W-1:0];
        dpp_pkg::CFG_TILT_LIMIT: tilt_limit_r <= cfg_if.data[dpp_pkg::LIM_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  assign pan_cfg.size   = width_r;
  assign pan_cfg.gain   = pan_gain_r;
  assign pan_cfg.limit  = pan_limit_r;
  assign pan_cfg.dead   = dead_r;
  assign tilt_cfg.size  = height_r;
  assign tilt_cfg.gain  = tilt_gain_r;
  assign tilt_cfg.limit = tilt_limit_r;
  assign tilt_cfg.dead  = dead_r;

  dpp_front u_front (
    .sun_x        (in_if.sun_x),
    .sun_y        (in_if.sun_y),
    .confidence   (in_if.confidence),
    .min_conf     (min_conf_r),
    .image_width  (width_r),
    .image_height (height_r),
    .job          (front_job)
  );

  assign in_if.ready = q_ready;

  dpp_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_if.valid),
    .push_data  (front_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_job)
  );

  dpp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .job         (q_job),
    .q_pop       (q_pop),
    .pan_cfg     (pan_cfg),
    .tilt_cfg    (tilt_cfg),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .pan_angle   (out_if.pan_angle),
    .tilt_angle  (out_if.tilt_angle),
    .gate_status (gate_out)
  );

  assign out_if.gate_status = gate_out;

  logic signed [dpp_pkg::ANG_W-1:0] pan_lim_s, tilt_lim_s;
  assign pan_lim_s  = $signed({1'b0, pan_limit_r});
  assign tilt_lim_s = $signed({1'b0, tilt_limit_r});

  a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.gate_status != dpp_pkg::GATE_TRACK)
    |-> (out_if.pan_angle == '0) && (out_if.tilt_angle == '0))
    else $error("gated beat carries nonzero angle");

  a_pan_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.pan_angle <= pan_lim_s) && (out_if.pan_angle >= -pan_lim_s))
    else $error("pan angle beyond limit");

  a_tilt_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.tilt_angle <= tilt_lim_s) && (out_if.tilt_angle >= -tilt_lim_s))
    else $error("tilt angle beyond limit");

endmodule

`default_nettype wire

FILE: verif/tb_deadband_proportional_pointing_core.sv
// Self-checking testbench for the deadband proportional pointing core.
module tb_deadband_proportional_pointing_core;
  import dpp_pkg::*;

  localparam int     CLK_HALF      = 6;
  localparam int     TIMEOUT       = 5_000_000;
  localparam int     MAX_REPORTS   = 10;
  localparam int     RANDOM_PHASES = 8;
  localparam int     PHASE_BEATS   = 66;
  localparam int     LONG_HOLD     = 150;
  localparam int     TAIL_CYCLES   = 60;
  localparam longint ERR_CEIL      = 131072;  // 4.0 in Q3.15
  localparam longint Q15_UNITY     = 32768;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(8);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

  typedef struct {
    logic signed [ANG_W-1:0] pan;
    logic signed [ANG_W-1:0] tilt;
    gate_t                   status;
  } setpoint_t;

  class setpoint_scoreboard;
    logic [CONF_W-1:0]        min_conf;
    logic [SIZE_W-1:0]        width;
    logic [SIZE_W-1:0]        height;
    logic [DEAD_W-1:0]        dead_zone;
    logic signed [GAIN_W-1:0] pan_gain;
    logic signed [GAIN_W-1:0] tilt_gain;
    logic [LIM_W-1:0]         pan_limit;
    logic [LIM_W-1:0]         tilt_limit;
    setpoint_t                pending_setpoints[$];
    int                       errors;

    function new();
      min_conf   = '0;
      width      = WIDTH_RST;
      height     = HEIGHT_RST;
      dead_zone  = '0;
      pan_gain   = '0;
      tilt_gain  = '0;
      pan_limit  = '0;
      tilt_limit = '0;
      errors     = 0;
    endfunction

    function int pending();
      return pending_setpoints.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_CONF:   min_conf   = data;
        CFG_WIDTH:      width      = data[SIZE_W-1:0];
        CFG_HEIGHT:     height     = data[SIZE_W-1:0];
        CFG_DEAD_ZONE:  dead_zone  = data[DEAD_W-1:0];
        CFG_PAN_GAIN:   pan_gain   = data;
        CFG_TILT_GAIN:  tilt_gain  = data;
        CFG_PAN_LIMIT:  pan_limit  = data[LIM_W-1:0];
        CFG_TILT_LIMIT: tilt_limit = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Normalize, deadband with rescale, gain, truncate, clamp.
    function logic signed [ANG_W-1:0] predict_axis(logic signed [SX_W-1:0] pos,
                                                    logic [SIZE_W-1:0] size,
                                                    logic signed [GAIN_W-1:0] gain,
                                                    logic [LIM_W-1:0] limit);
      longint offs, abs_offs, err, dz, scaled, abs_gain, mag;
      bit     offs_neg, gain_neg;
      offs     = longint'(pos) - 8 * longint'(size);
      offs_neg = offs < 0;
      abs_offs = offs_neg ? -offs : offs;
      err      = (abs_offs << ERR_SHIFT) / longint'(size);
      if (err > ERR_CEIL) err = ERR_CEIL;
      dz = longint'(dead_zone);
      if (err <= dz) return '0;
      scaled   = ((err - dz) * Q15_UNITY) / (Q15_UNITY - dz);
      gain_neg = gain < 0;
      abs_gain = gain_neg ? -longint'(gain) : longint'(gain);
      mag      = (abs_gain * scaled) >> GAIN_SHIFT;
      if (mag > longint'(limit)) mag = longint'(limit);
      return (offs_neg != gain_neg) ? ANG_W'(-mag) : ANG_W'(mag);
    endfunction

    function void note_input(logic signed [SX_W-1:0] x, y, logic [CONF_W-1:0] conf);
      setpoint_t sp;
      sp.pan  = '0;
      sp.tilt = '0;
      if (conf < min_conf) begin
        sp.status = GATE_LOW_CONF;
      end else if (width == 0 || height == 0) begin
        sp.status = GATE_BAD_SIZE;
      end else begin
        sp.status = GATE_TRACK;
        sp.pan    = predict_axis(x, width, pan_gain, pan_limit);
        sp.tilt   = predict_axis(y, height, tilt_gain, tilt_limit);
      end
      pending_setpoints.push_back(sp);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", what);
    endfunction

    function void check_result(logic signed [ANG_W-1:0] pan, tilt,
                               logic [STATUS_W-1:0] status);
      setpoint_t sp;
      if (pending_setpoints.size() == 0) begin
        flag($sformatf("result beat with nothing expected: pan=%0d tilt=%0d status=%0d",
                       pan, tilt, status));
        return;
      end
      sp = pending_setpoints.pop_front();
      if (pan !== sp.pan || tilt !== sp.tilt || status !== sp.status)
        flag($sformatf({"setpoint mismatch: expected pan=%0d tilt=%0d status=%0d,",
                        " got pan=%0d tilt=%0d status=%0d"},
                       sp.pan, sp.tilt, sp.status, pan, tilt, status));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dpp_in_if  in_ch ();
  dpp_out_if out_ch ();
  dpp_cfg_if cfg_ch ();

  deadband_proportional_pointing_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  setpoint_scoreboard sb;
  bit                 idle_on;
  int                 hold_request;

  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.sun_x, in_ch.sun_y, in_ch.confidence);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.pan_angle, out_ch.tilt_angle, out_ch.gate_status);
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(int x, int y, int conf);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sun_x      <= SX_W'(x);
    in_ch.sun_y      <= SX_W'(y);
    in_ch.confidence <= CONF_W'(conf);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait for every outstanding setpoint.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Writes all eight registers, then one unmapped index that must be dropped.
  task automatic program_regs(logic [CFG_DATA_W-1:0] mc, w, h, dz, pg, tg, pl, tl);
    logic [CFG_IDX_W-1:0]  idx[9];
    logic [CFG_DATA_W-1:0] val[9];
    idx = '{CFG_MIN_CONF, CFG_WIDTH, CFG_HEIGHT, CFG_DEAD_ZONE, CFG_PAN_GAIN,
            CFG_TILT_GAIN, CFG_PAN_LIMIT, CFG_TILT_LIMIT,
            CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST))};
    val = '{mc, w, h, dz, pg, tg, pl, tl, CFG_DATA_W'($urandom)};
    for (int i = 0; i < 9; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int pick(int lo_end, int hi_end, int lo, int hi);
    case ($urandom_range(0, 7))
      0:       return lo_end;
      1:       return hi_end;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Unused upper bits of narrow registers carry junk to check masking.
  task automatic random_config();
    program_regs(16'(pick(0, 65535, 0, 24576)),
                 16'(pick(1, 4095, 16, 2047)) | {4'($urandom), 12'd0},
                 16'(pick(1, 4095, 16, 2047)) | {4'($urandom), 12'd0},
                 16'(pick(0, 32767, 0, 12000)) | {1'($urandom), 15'd0},
                 16'(pick(32767, 32768, 0, 65535)),
                 16'(pick(32767, 32768, 0, 65535)),
                 16'(pick(0, 32767, 0, 32767)) | {1'($urandom), 15'd0},
                 16'(pick(0, 32767, 0, 32767)) | {1'($urandom), 15'd0});
  endtask

  // Mostly positions inside the image, some anywhere in the field range.
  task automatic random_beat();
    int x, y, conf;
    if ($urandom_range(0, 3) == 0) x = $urandom_range(0, 131071) - 65536;
    else x = $urandom_range(0, 16 * sb.width);
    if ($urandom_range(0, 3) == 0) y = $urandom_range(0, 131071) - 65536;
    else y = $urandom_range(0, 16 * sb.height);
    if ($urandom_range(0, 5) == 0) conf = $urandom_range(0, 65535);
    else conf = $urandom_range(65535, sb.min_conf);
    send_beat(x, y, conf);
  endtask

  initial begin
    sb           = new();
    idle_on      = 1'b1;
    hold_request = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.sun_x      <= '0;
    in_ch.sun_y      <= '0;
    in_ch.confidence <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero gains, so tracking beats give zero setpoints
    send_beat(0, 0, 0);
    send_beat(65535, -65536, 16'hFFFF);
    drain();

    // 640x480 (width with junk upper bits), deadband near 0.03
    program_regs(16'h8000, 16'hF280, 480, 1000, 16'h1000, 16'hF000, 20000, 32767);
    send_beat(5120, 3840, 16'hFFFF);
    send_beat(5270, 3690, 16'h8000);
    send_beat(5280, 3680, 16'h8000);
    send_beat(10240, 0, 16'h9000);
    send_beat(65535, -65536, 16'hFFFF);
    send_beat(-65536, 65535, 16'hFFFF);
    send_beat(0, 0, 16'h7FFF);
    drain();

    // smallest and largest sizes, widest deadband, gain extremes
    program_regs(16'h0000, 16'h0001, 16'h0FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                 16'h0000, 16'h7FFF);
    send_beat(8, 32760, 0);
    send_beat(9, 32761, 16'h1234);
    send_beat(65535, -65536, 16'hFFFF);
    send_beat(-65536, 65535, 16'hFFFF);
    send_beat(40, 0, 16'hFFFF);
    drain();

    // zero width; low confidence takes priority over it
    program_regs(16'hFFFF, 16'h0000, 480, 0, 16'h7FFF, 16'h7FFF, 32767, 32767);
    send_beat(100, 100, 16'hFFFF);
    send_beat(100, 100, 16'hFFFE);
    drain();

    // zero height, upper junk bits set
    program_regs(16'h0000, 640, 16'hF000, 0, 16'h4000, 16'hC000, 16'h7FFF, 16'h7FFF);
    send_beat(1000, 1000, 0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      random_config();
      idle_on = (ph % 3 != 2) && (ph < RANDOM_PHASES - 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // fill the block while results are held back
        if (ph == 2 && n == 10) hold_request = LONG_HOLD;
        random_beat();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("Regression FAIL");
    $finish;
  end

endmodule
